// ===== design/note_tone_generator_macros.svh =====
// Assertion macros used by the tone generator checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef NOTE_TONE_GENERATOR_MACROS_SVH
`define NOTE_TONE_GENERATOR_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define NTG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent checked in the same cycle
`define NTG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/ntg_pkg.sv =====
// Package for the note tone generator: command codes, defaults and note table.
// No dependencies.
package ntg_pkg;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_NOTE    = 2'd1,
		CMD_RAW     = 2'd2,
		CMD_SILENCE = 2'd3
	} cmd_t;

	localparam int unsigned FAST_DIVIDE_DEF = 64;
	localparam int unsigned SLOW_DIVIDE_DEF = 256;

	localparam logic [6:0] NOTE_FIRST     = 7'd45;
	localparam logic [6:0] NOTE_LAST      = 7'd81;
	localparam logic [6:0] NOTE_FAST_FROM = 7'd59;
	localparam logic [7:0] RESET_COMPARE  = 8'd74;

	// compare value for note NOTE_FIRST + idx
	function automatic logic [7:0] note_cmp(input logic [5:0] idx);
		logic [7:0] v;
		case (idx)
			6'd0:  v = 8'd141;
			6'd1:  v = 8'd133;
			6'd2:  v = 8'd126;
			6'd3:  v = 8'd118;
			6'd4:  v = 8'd112;
			6'd5:  v = 8'd105;
			6'd6:  v = 8'd99;
			6'd7:  v = 8'd94;
			6'd8:  v = 8'd88;
			6'd9:  v = 8'd83;
			6'd10: v = 8'd79;
			6'd11: v = 8'd74;
			6'd12: v = 8'd70;
			6'd13: v = 8'd66;
			6'd14: v = 8'd252;
			6'd15: v = 8'd238;
			6'd16: v = 8'd224;
			6'd17: v = 8'd212;
			6'd18: v = 8'd200;
			6'd19: v = 8'd189;
			6'd20: v = 8'd178;
			6'd21: v = 8'd168;
			6'd22: v = 8'd158;
			6'd23: v = 8'd149;
			6'd24: v = 8'd141;
			6'd25: v = 8'd133;
			6'd26: v = 8'd126;
			6'd27: v = 8'd118;
			6'd28: v = 8'd112;
			6'd29: v = 8'd105;
			6'd30: v = 8'd99;
			6'd31: v = 8'd94;
			6'd32: v = 8'd88;
			6'd33: v = 8'd83;
			6'd34: v = 8'd79;
			6'd35: v = 8'd74;
			6'd36: v = 8'd70;
			default: v = RESET_COMPARE;
		endcase
		return v;
	endfunction

endpackage

// ===== design/note_tone_generator.sv =====
// Square-wave tone generator: prescaled 8-bit clear-on-match timer driven by commands.
// Depends on ntg_pkg.
//
// One command transaction is accepted every cycle in which input ready is high; its
// result (tone level and sound-on flag after the update) appears in the output
// register on the next cycle. The block updates its timer state and loads the output
// register in the same edge, so throughput is one transaction per cycle, and input
// ready only drops while a result sits in the output register and is not taken.
module note_tone_generator
	import ntg_pkg::*;
#(
	parameter int unsigned FAST_DIVIDE = FAST_DIVIDE_DEF,
	parameter int unsigned SLOW_DIVIDE = SLOW_DIVIDE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [6:0] note,
	input  logic [7:0] raw_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       tone_out,
	output logic       playing
);

	localparam logic [8:0] FAST_DIV9 = 9'(FAST_DIVIDE);
	localparam logic [8:0] SLOW_DIV9 = 9'(SLOW_DIVIDE);

	logic [7:0] prescale_q, prescale_d;
	logic [7:0] timer_q, timer_d;
	logic [7:0] compare_q, compare_d;
	logic       slow_q, slow_d;
	logic       enabled_q, enabled_d;
	logic       level_q, level_d;
	logic       out_valid_q;

	logic       accept;
	logic [8:0] pre_next;
	logic [8:0] div_sel;
	logic       note_in_range;
	logic [5:0] note_off;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign pre_next      = {1'b0, prescale_q} + 9'd1;
	assign div_sel       = slow_q ? SLOW_DIV9 : FAST_DIV9;
	assign note_in_range = (note >= NOTE_FIRST) && (note <= NOTE_LAST);
	assign note_off      = 6'(note - NOTE_FIRST);

	always_comb begin
		prescale_d = prescale_q;
		timer_d    = timer_q;
		compare_d  = compare_q;
		slow_d     = slow_q;
		enabled_d  = enabled_q;
		level_d    = level_q;
		case (cmd_t'(cmd))
			CMD_TICK: begin
				if (pre_next < div_sel) begin
					prescale_d = pre_next[7:0];
				end else begin
					prescale_d = 8'd0;
					if (timer_q == compare_q) begin
						timer_d = 8'd0;
						if (enabled_q) begin
							level_d = !level_q;
						end
					end else begin
						timer_d = timer_q + 8'd1;
					end
				end
			end
			CMD_NOTE: begin
				slow_d = (note < NOTE_FAST_FROM);
				if (note_in_range) begin
					compare_d = note_cmp(note_off);
					enabled_d = 1'b1;
				end else begin
					enabled_d = 1'b0;
				end
			end
			CMD_RAW: begin
				slow_d    = 1'b0;
				compare_d = raw_value;
				enabled_d = 1'b1;
			end
			default: begin
				enabled_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= 8'd0;
			timer_q     <= 8'd0;
			compare_q   <= RESET_COMPARE;
			slow_q      <= 1'b0;
			enabled_q   <= 1'b0;
			level_q     <= 1'b0;
			out_valid_q <= 1'b0;
			tone_out    <= 1'b0;
			playing     <= 1'b0;
		end else begin
			if (accept) begin
				prescale_q  <= prescale_d;
				timer_q     <= timer_d;
				compare_q   <= compare_d;
				slow_q      <= slow_d;
				enabled_q   <= enabled_d;
				level_q     <= level_d;
				tone_out    <= level_d;
				playing     <= enabled_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/ntg_checker.sv =====
// Port-level assertions for the note tone generator, bound to the top level.
// Depends on ntg_pkg and note_tone_generator_macros.svh.
`include "note_tone_generator_macros.svh"

module ntg_checker
	import ntg_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] cmd,
	input logic [6:0] note,
	input logic [7:0] raw_value,
	input logic       out_valid,
	input logic       out_ready,
	input logic       tone_out,
	input logic       playing
);

	logic       in_fire;
	logic       note_bad;
	logic       out_stall;
	logic       off_fire;
	logic       raw_fire;
	logic       other_fire;
	logic [1:0] result_bits;

	assign in_fire     = in_valid && in_ready;
	assign note_bad    = (note < NOTE_FIRST) || (note > NOTE_LAST);
	assign out_stall   = out_valid && !out_ready;
	assign off_fire    = in_fire && (cmd == CMD_SILENCE || (cmd == CMD_NOTE && note_bad));
	assign raw_fire    = in_fire && cmd == CMD_RAW;
	assign other_fire  = in_fire && cmd != CMD_TICK;
	assign result_bits = {tone_out, playing};

	// stalled result holds
	`NTG_ASSERT_NEXT(a_hold, out_stall, out_valid && $stable(result_bits), "stalled result changed")
	// silence, or a note out of range, leaves sound off
	`NTG_ASSERT_NEXT(a_off, off_fire, out_valid && !playing, "sound on after silence")
	// raw play turns sound on
	`NTG_ASSERT_NEXT(a_raw_on, raw_fire, out_valid && playing, "sound off after raw play")
	// only a tick moves the level
	`NTG_ASSERT_NEXT(a_level_frozen, other_fire, $stable(tone_out), "level changed without a tick")
	// a pending result that is not taken blocks input
	`NTG_ASSERT_SAME(a_ready_block, out_stall, !in_ready, "input taken over a stalled result")

endmodule

bind note_tone_generator ntg_checker u_ntg_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for note_tone_generator: drives command transactions, predicts
// tone level and sound-on flag per command, and compares every result in order.
// Depends on ntg_pkg and design/note_tone_generator.sv.
module tb;
	import ntg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic tone;
		logic snd;
	} tone_result_t;

	// compare values for notes NOTE_FIRST..NOTE_LAST, first note in the top byte
	localparam logic [37*8-1:0] NOTE_PERIODS = {
		8'd141, 8'd133, 8'd126, 8'd118, 8'd112, 8'd105, 8'd99, 8'd94, 8'd88, 8'd83,
		8'd79, 8'd74, 8'd70, 8'd66, 8'd252, 8'd238, 8'd224, 8'd212, 8'd200, 8'd189,
		8'd178, 8'd168, 8'd158, 8'd149, 8'd141, 8'd133, 8'd126, 8'd118, 8'd112,
		8'd105, 8'd99, 8'd94, 8'd88, 8'd83, 8'd79, 8'd74, 8'd70
	};

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [1:0] cmd       = 2'd0;
	logic [6:0] note      = 7'd0;
	logic [7:0] raw_value = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       tone_out;
	logic       playing;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int fail_count     = 0;

	// predicted generator state
	logic [7:0] pre_cnt  = 8'd0;
	logic [7:0] tmr_cnt  = 8'd0;
	logic [7:0] cmp_val  = RESET_COMPARE;
	logic       slow_div = 1'b0;
	logic       snd_en   = 1'b0;
	logic       lvl      = 1'b0;

	tone_result_t tone_q[$];

	note_tone_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.note      (note),
		.raw_value (raw_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tone_out  (tone_out),
		.playing   (playing)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#800_000;
		$display("note_tone_generator verification failed");
		$finish;
	end

	task automatic predict_tone(input cmd_t c, input logic [6:0] n, input logic [7:0] r);
		logic [8:0] div;
		logic [8:0] nxt;
		int idx;
		tone_result_t res;
		case (c)
			CMD_TICK: begin
				div = slow_div ? 9'(SLOW_DIVIDE_DEF) : 9'(FAST_DIVIDE_DEF);
				nxt = {1'b0, pre_cnt} + 9'd1;
				if (nxt < div) begin
					pre_cnt = nxt[7:0];
				end else begin
					pre_cnt = 8'd0;
					if (tmr_cnt == cmp_val) begin
						tmr_cnt = 8'd0;
						if (snd_en)
							lvl = ~lvl;
					end else begin
						tmr_cnt = tmr_cnt + 8'd1;
					end
				end
			end
			CMD_NOTE: begin
				slow_div = (n < NOTE_FAST_FROM);
				if (n >= NOTE_FIRST && n <= NOTE_LAST) begin
					idx = int'(n) - int'(NOTE_FIRST);
					cmp_val = NOTE_PERIODS[(36 - idx) * 8 +: 8];
					snd_en = 1'b1;
				end else begin
					snd_en = 1'b0;
				end
			end
			CMD_RAW: begin
				slow_div = 1'b0;
				cmp_val = r;
				snd_en = 1'b1;
			end
			default: begin
				snd_en = 1'b0;
			end
		endcase
		res.tone = lvl;
		res.snd = snd_en;
		tone_q.push_back(res);
	endtask

	task automatic send_cmd(input cmd_t c, input logic [6:0] n, input logic [7:0] r);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		note <= n;
		raw_value <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_tone(c, n, r);
	endtask

	// ticks carry random junk in the unused fields
	task automatic tick_burst(input int count);
		repeat (count)
			send_cmd(CMD_TICK, 7'($urandom), 8'($urandom));
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin : check_result
		tone_result_t want;
		if (out_valid && out_ready) begin
			if (tone_q.size() == 0) begin
				$error("result transaction with nothing expected");
				fail_count++;
			end else begin
				want = tone_q.pop_front();
				if (tone_out !== want.tone) begin
					$error("tone_out: expected %0b, got %0b", want.tone, tone_out);
					fail_count++;
				end
				if (playing !== want.snd) begin
					$error("playing: expected %0b, got %0b", want.snd, playing);
					fail_count++;
				end
			end
		end
	end

	task automatic test_commands();
		tick_burst(2);
		send_cmd(CMD_NOTE, 7'd44, 8'hFF);
		send_cmd(CMD_NOTE, NOTE_FIRST, 8'h00);
		send_cmd(CMD_NOTE, 7'd58, 8'h55);
		send_cmd(CMD_NOTE, NOTE_FAST_FROM, 8'hAA);
		send_cmd(CMD_NOTE, NOTE_LAST, 8'h00);
		send_cmd(CMD_NOTE, 7'd82, 8'hFF);
		send_cmd(CMD_NOTE, 7'd0, 8'h00);
		send_cmd(CMD_NOTE, 7'd127, 8'hFF);
		send_cmd(CMD_RAW, 7'd127, 8'd255);
		send_cmd(CMD_SILENCE, 7'd0, 8'd0);
		send_cmd(CMD_RAW, 7'd0, 8'd0);
		send_cmd(CMD_SILENCE, 7'd127, 8'd255);
		send_cmd(CMD_NOTE, 7'd70, 8'd0);
		send_cmd(CMD_SILENCE, 7'd70, 8'd0);
		tick_burst(3);
	endtask

	// slow prescaler run past the fast period, then fast divide takes over
	task automatic test_divider_switch();
		send_cmd(CMD_NOTE, NOTE_FIRST, 8'd0);
		tick_burst(100);
		send_cmd(CMD_RAW, 7'd0, 8'd0);
		tick_burst(70);
	endtask

	// matches while silent clear the timer but leave the level alone
	task automatic test_silent_match();
		send_cmd(CMD_RAW, 7'd0, 8'd0);
		tick_burst(70);
		send_cmd(CMD_SILENCE, 7'd0, 8'd0);
		tick_burst(140);
		send_cmd(CMD_RAW, 7'd0, 8'd1);
		tick_burst(140);
	endtask

	// compare dropped below the running timer: no match, the count carries on
	task automatic test_timer_wrap();
		send_cmd(CMD_RAW, 7'd0, 8'd255);
		tick_burst(64 * 3);
		send_cmd(CMD_RAW, 7'd0, 8'd1);
		tick_burst(64 * 2);
	endtask

	task automatic test_random(input int count);
		int sent;
		int pick;
		int burst;
		logic [7:0] r;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			burst = $urandom_range(8, 90);
			if (pick < 45) begin
				r = ($urandom_range(9) < 6) ? 8'($urandom_range(3)) : 8'($urandom);
				send_cmd(CMD_RAW, 7'($urandom), r);
			end else if (pick < 70) begin
				if ($urandom_range(3) == 0)
					send_cmd(CMD_NOTE, 7'($urandom), 8'($urandom));
				else
					send_cmd(CMD_NOTE, 7'($urandom_range(40, 86)), 8'($urandom));
			end else if (pick < 82) begin
				send_cmd(CMD_SILENCE, 7'($urandom), 8'($urandom));
			end else begin
				send_cmd(cmd_t'($urandom_range(3)), 7'($urandom), 8'($urandom));
				burst = $urandom_range(0, 4);
			end
			tick_burst(burst);
			sent += burst + 1;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 13;
		sink_stall_pct = 68;
		test_commands();
		test_divider_switch();
		test_silent_match();
		test_random(70);

		src_idle_pct = 68;
		sink_stall_pct = 13;
		test_random(70);

		src_idle_pct = 0;
		sink_stall_pct = 0;
		test_timer_wrap();
		test_random(70);

		@(negedge clk);
		in_valid <= 1'b0;
		while (tone_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("note_tone_generator verification clean");
		else
			$display("note_tone_generator verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/ntg_pkg.sv
design/note_tone_generator.sv
design/ntg_checker.sv
bench/tb.sv
